### sv/tq_pkg.sv
package tq_pkg;

  localparam int SLOT_COUNT_DEF = 16;

  typedef enum logic [1:0] {
    CMD_SCHEDULE = 2'd0,
    CMD_CANCEL   = 2'd1,
    CMD_RUN      = 2'd2
  } tq_cmd_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_INVALID   = 2'd1,
    ST_NOT_FOUND = 2'd2
  } tq_status_t;

  typedef struct packed {
    tq_cmd_t     cmd;
    logic [3:0]  slot;
    logic [31:0] ident;
  } tq_req_t;

  typedef struct packed {
    tq_status_t  status;
    logic [31:0] ident;
  } tq_rsp_t;

endpackage

### sv/tq_store.sv
module tq_store
  import tq_pkg::*;
#(
  parameter int SLOT_COUNT = SLOT_COUNT_DEF
) (
  input  logic    clk,
  input  logic    rst,
  input  logic    exec,
  input  tq_req_t req,
  output tq_rsp_t rsp
);

  localparam int SW = $clog2(SLOT_COUNT);
  localparam int CW = $clog2(SLOT_COUNT + 1);

  logic [SLOT_COUNT-1:0] busy;
  logic [CW-1:0]         count;
  logic [31:0]           counter;
  logic [31:0]           order_ident [SLOT_COUNT];
  logic [SW-1:0]         order_slot  [SLOT_COUNT];

  logic [SLOT_COUNT-1:0] hit;
  logic [SLOT_COUNT-1:0] rm_first;
  logic [SLOT_COUNT-1:0] rm_tail;
  logic [SW-1:0]         rm_slot;
  logic [SW-1:0]         slot_idx;
  logic [31:0]           id_next;
  logic                  slot_ok;
  logic                  full;
  logic                  do_push;
  logic                  do_remove;

  assign slot_ok  = 32'(req.slot) < 32'(SLOT_COUNT);
  assign slot_idx = SW'(req.slot);
  assign full     = count == CW'(SLOT_COUNT);
  assign id_next  = (counter == 32'hFFFF_FFFF) ? 32'd1 : counter + 32'd1;

  // positions at or behind the removed one shift toward the head
  assign rm_tail  = ~(rm_first - SLOT_COUNT'(1));

  always_comb begin
    for (int i = 0; i < SLOT_COUNT; i++) begin
      hit[i] = (CW'(i) < count) && (order_ident[i] == req.ident) && (req.ident != 32'd0);
    end
  end

  always_comb begin
    rm_slot = '0;
    for (int i = 0; i < SLOT_COUNT; i++) begin
      rm_slot = rm_slot | (order_slot[i] & {SW{rm_first[i]}});
    end
  end

  always_comb begin
    rsp.status = ST_INVALID;
    rsp.ident  = 32'd0;
    do_push    = 1'b0;
    do_remove  = 1'b0;
    rm_first   = '0;
    unique case (req.cmd)
      CMD_SCHEDULE: begin
        if (slot_ok && !busy[slot_idx] && !full) begin
          do_push    = 1'b1;
          rsp.status = ST_OK;
          rsp.ident  = id_next;
        end
      end
      CMD_CANCEL: begin
        rsp.status = ST_NOT_FOUND;
        if (|hit) begin
          // nearest match to the head wins
          rm_first   = hit & (~hit + SLOT_COUNT'(1));
          do_remove  = 1'b1;
          rsp.status = ST_OK;
        end
      end
      CMD_RUN: begin
        if (count == '0) begin
          rsp.status = ST_NOT_FOUND;
        end else begin
          rm_first   = SLOT_COUNT'(1);
          do_remove  = 1'b1;
          rsp.status = ST_OK;
          rsp.ident  = order_ident[0];
        end
      end
      default: begin
        rsp.status = ST_INVALID;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy    <= '0;
      count   <= '0;
      counter <= 32'd0;
    end else if (exec) begin
      if (do_push) begin
        busy[slot_idx] <= 1'b1;
        count          <= count + CW'(1);
        counter        <= id_next;
      end else if (do_remove) begin
        busy[rm_slot] <= 1'b0;
        count         <= count - CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (exec) begin
      if (do_push) begin
        order_ident[count[SW-1:0]] <= id_next;
        order_slot[count[SW-1:0]]  <= slot_idx;
      end else if (do_remove) begin
        for (int i = 0; i < SLOT_COUNT - 1; i++) begin
          if (rm_tail[i]) begin
            order_ident[i] <= order_ident[i+1];
            order_slot[i]  <= order_slot[i+1];
          end
        end
      end
    end
  end

endmodule

### sv/cancellable_fifo_task_queue.sv
// path: a word waits in the input register, the store executes it, and the
// result is registered at the output; throughput: one word per cycle unless
// out_stall holds the output, each command in one store compare-and-shift pass
// reset: synchronous, clears the pipeline, the slot busy flags, the queue
// count and the id counter; queue order entries need no reset
module cancellable_fifo_task_queue
  import tq_pkg::*;
#(
  parameter int SLOT_COUNT = SLOT_COUNT_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  cmd,
  input  logic [3:0]  slot,
  input  logic [31:0] task_ident,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  status,
  output logic [31:0] result_ident
);

  logic    s1_valid;
  tq_req_t s1_req;
  tq_rsp_t rsp;
  logic    move;
  logic    in_take;

  assign move     = s1_valid && (!out_valid || !out_stall);
  assign in_stall = s1_valid && !move;
  assign in_take  = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= in_take || (s1_valid && !move);
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_req.cmd   <= tq_cmd_t'(cmd);
      s1_req.slot  <= slot;
      s1_req.ident <= task_ident;
    end
  end

  tq_store #(
    .SLOT_COUNT(SLOT_COUNT)
  ) u_store (
    .clk (clk),
    .rst (rst),
    .exec(move),
    .req (s1_req),
    .rsp (rsp)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (move) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (move) begin
      status       <= rsp.status;
      result_ident <= rsp.ident;
    end
  end

`ifndef SYNTHESIS
  a_held_word: assert property (@(posedge clk) disable iff (rst)
    s1_valid && !move |=> s1_valid && $stable(s1_req))
    else $error("pending word lost or changed");

  a_move_fills: assert property (@(posedge clk) disable iff (rst)
    move |=> out_valid)
    else $error("executed word gave no result");

  a_sched_ident: assert property (@(posedge clk) disable iff (rst)
    move && s1_req.cmd == CMD_SCHEDULE && rsp.status == ST_OK |-> rsp.ident != 32'd0)
    else $error("schedule handed out id zero");

  a_cancel_ident: assert property (@(posedge clk) disable iff (rst)
    move && s1_req.cmd == CMD_CANCEL |-> rsp.ident == 32'd0 && rsp.status != ST_INVALID)
    else $error("cancel result malformed");
`endif

endmodule
